@@ src/xctfp_pkg.sv @@
package xctfp_pkg;

  // frame geometry; byte 0 is the leading dollar sign
  localparam int unsigned FRAME_LEN = 24;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned TAG_FIRST = 13;
  localparam int unsigned TAG_LAST  = 16;

  localparam logic [CNT_W-1:0] CNT_XOR_LAST = CNT_W'(FRAME_LEN - 4);
  localparam logic [CNT_W-1:0] CNT_CHK_HI   = CNT_W'(FRAME_LEN - 3);
  localparam logic [CNT_W-1:0] CNT_CHK_LO   = CNT_W'(FRAME_LEN - 2);
  localparam logic [CNT_W-1:0] CNT_FRAME    = CNT_W'(FRAME_LEN);
  localparam logic [CNT_W-1:0] CNT_TAG_LO   = CNT_W'(TAG_FIRST);
  localparam logic [CNT_W-1:0] CNT_TAG_HI   = CNT_W'(TAG_LAST);

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h41;

  localparam logic [7:0] IDLE_LIMIT_RST = 8'd100;

  // input item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_DOLLAR = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        frame_ok;
    logic [15:0] tag_number;
    logic        site_update;
  } out_item_t;

  // nibble to uppercase ascii hex
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'd0, nib};
    end else begin
      r = CH_A + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

@@ src/xor_checked_ascii_tag_frame_parser_unit.sv @@
// result path: the closing byte passes the input stage, then the result register
// throughput: one transaction per cycle while out_ready does not stall the result
//   register; the single input stage feeds the frame state update and that register
// reset: synchronous active-low rst_n returns to hunting, clears counters and
//   loads the idle poll limit with 100
module xor_checked_ascii_tag_frame_parser_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  xctfp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output xctfp_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);
  import xctfp_pkg::*;

  // input stage
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     s1_adv;

  // frame state
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       running_xor_r, running_xor_nxt;
  logic [7:0]       check_hi_r, check_hi_nxt;
  logic [7:0]       check_lo_r, check_lo_nxt;
  logic [15:0]      number_accum_r, number_accum_nxt;
  logic [7:0]       idle_polls_r, idle_polls_nxt;
  logic [7:0]       idle_limit_r;

  // result stage
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      emit;
  out_item_t res;

  logic [7:0]  b;
  logic [7:0]  idle_inc;
  logic [CNT_W-1:0] cnt_inc;
  logic [15:0] digit;
  logic        ok;

  assign b        = s1_item_r.rx_byte;
  assign idle_inc = idle_polls_r + 8'd1;
  assign cnt_inc  = byte_count_r + CNT_W'(1);
  assign digit    = {8'd0, b} - {8'd0, CH_ZERO};

  // handshakes
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // result valid: set by a closing byte, held until taken
  assign out_valid_nxt = (s1_adv && emit) || (out_valid_r && !out_ready);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (s1_item_r.func == FUNC_POLL) begin
      if (idle_inc >= idle_limit_r) begin
        phase_nxt = PH_HUNT;
      end
    end else begin
      case (phase_r)
        PH_DOLLAR: begin
          phase_nxt = (b == CH_F) ? PH_BODY : PH_HUNT;
        end
        PH_BODY: begin
          if (cnt_inc >= CNT_FRAME) begin
            phase_nxt = PH_HUNT;
          end
        end
        default: begin
          phase_nxt = (b == CH_DOLLAR) ? PH_DOLLAR : PH_HUNT;
        end
      endcase
    end
  end

  // datapath updates and result
  always_comb begin
    byte_count_nxt   = byte_count_r;
    running_xor_nxt  = running_xor_r;
    check_hi_nxt     = check_hi_r;
    check_lo_nxt     = check_lo_r;
    number_accum_nxt = number_accum_r;
    idle_polls_nxt   = idle_polls_r;
    emit             = 1'b0;
    ok               = 1'b0;
    res              = '0;
    if (s1_item_r.func == FUNC_POLL) begin
      idle_polls_nxt = idle_inc;
      if (idle_inc >= idle_limit_r) begin
        idle_polls_nxt = '0;
        byte_count_nxt = '0;
      end
    end else begin
      idle_polls_nxt = '0;
      case (phase_r)
        PH_DOLLAR: begin
          if (b == CH_F) begin
            byte_count_nxt  = CNT_W'(2);
            running_xor_nxt = b;
          end
        end
        PH_BODY: begin
          if (byte_count_r <= CNT_XOR_LAST) begin
            running_xor_nxt = running_xor_r ^ b;
          end
          if (byte_count_r >= CNT_TAG_LO && byte_count_r <= CNT_TAG_HI) begin
            number_accum_nxt = {number_accum_r[12:0], 3'b000}
                             + {number_accum_r[14:0], 1'b0} + digit;
          end
          if (byte_count_r == CNT_CHK_HI) begin
            check_hi_nxt = b;
          end
          if (byte_count_r == CNT_CHK_LO) begin
            check_lo_nxt = b;
          end
          byte_count_nxt = cnt_inc;
          if (cnt_inc >= CNT_FRAME) begin
            ok = (b == CH_HASH)
              && (check_hi_nxt == hex_char(running_xor_nxt[7:4]))
              && (check_lo_nxt == hex_char(running_xor_nxt[3:0]));
            emit            = 1'b1;
            byte_count_nxt  = '0;
            res.frame_ok    = ok;
            res.tag_number  = ok ? number_accum_nxt : 16'd0;
            res.site_update = ok && (number_accum_nxt != 16'd0);
          end
        end
        default: begin
          if (b == CH_DOLLAR) begin
            byte_count_nxt   = CNT_W'(1);
            running_xor_nxt  = '0;
            number_accum_nxt = '0;
            check_hi_nxt     = '0;
            check_lo_nxt     = '0;
          end
        end
      endcase
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      phase_r        <= PH_HUNT;
      byte_count_r   <= '0;
      running_xor_r  <= '0;
      check_hi_r     <= '0;
      check_lo_r     <= '0;
      number_accum_r <= '0;
      idle_polls_r   <= '0;
      idle_limit_r   <= IDLE_LIMIT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        idle_limit_r <= cfg_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        phase_r        <= phase_nxt;
        byte_count_r   <= byte_count_nxt;
        running_xor_r  <= running_xor_nxt;
        check_hi_r     <= check_hi_nxt;
        check_lo_r     <= check_lo_nxt;
        number_accum_r <= number_accum_nxt;
        idle_polls_r   <= idle_polls_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
    if (s1_adv && emit) begin
      out_item_r <= res;
    end
  end

endmodule
